// ----- sv/dfc_pkg.sv -----
// ----------------------------------------------------------------------------
// dfc_pkg: shared types and constants of the delimited field cutter
// Holds the register index codes, fixed byte codes and the request record
// that travels from the front to the back through the request queue.
// ----------------------------------------------------------------------------
package dfc_pkg;

  localparam logic [7:0] NL_BYTE  = 8'h0A;
  localparam logic [7:0] TAB_BYTE = 8'h09;

  // Widest hold count over the supported hold depths (up to 256 entries).
  localparam int HOLD_CNT_W = 9;
  // The output delimiter never exceeds four bytes.
  localparam int JOIN_BYTES_MAX = 4;

  typedef enum logic [2:0] {
    CFG_SPLIT_CHAR  = 3'd0,
    CFG_JOIN_BYTES  = 3'd1,
    CFG_JOIN_LEN    = 3'd2,
    CFG_PICK_MASK   = 3'd3,
    CFG_PICK_FROM   = 3'd4,
    CFG_DROP_PLAIN  = 3'd5
  } cfg_idx_t;

  // One request: first flush_n held bytes, then tail_len bytes of tail_data.
  typedef struct packed {
    logic [HOLD_CNT_W-1:0]         flush_n;
    logic [2:0]                    tail_len;
    logic [8*JOIN_BYTES_MAX-1:0]   tail_data;
    logic                          ovf;
    logic                          line_end;
  } cmd_t;

endpackage

// ----- sv/dfc_ram.sv -----
// ----------------------------------------------------------------------------
// dfc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- sv/dfc_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// dfc_cmd_queue: two-entry request queue between front and back
// Lets the front accept input while the back is still emitting bytes.
// ----------------------------------------------------------------------------
module dfc_cmd_queue
  import dfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= din;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/dfc_front.sv -----
// ----------------------------------------------------------------------------
// dfc_front: input classifier of the delimited field cutter
// Holds the configuration, tracks the field number and line flags, stores
// held first-field bytes and issues at most one output request per input item.
// ----------------------------------------------------------------------------
module dfc_front
  import dfc_pkg::*;
#(
  parameter int HOLD_DEPTH  = 32,
  parameter int MASK_FIELDS = 64,
  parameter int JOIN_MAX    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_has,
  input  logic                          in_last,
  input  logic                          q_full,
  output logic                          q_push,
  output cmd_t                          q_cmd,
  output logic                          hold_we,
  output logic [$clog2(HOLD_DEPTH)-1:0] hold_waddr,
  output logic [7:0]                    hold_wdata,
  input  logic                          flush_done,
  output logic                          flush_pend
);

  localparam int AW       = $clog2(HOLD_DEPTH);
  localparam int CW       = $clog2(HOLD_DEPTH + 1);
  localparam int MIW      = $clog2(MASK_FIELDS);
  localparam int JOIN_LIM = (JOIN_MAX < JOIN_BYTES_MAX) ? JOIN_MAX : JOIN_BYTES_MAX;
  localparam int JW       = 8 * JOIN_LIM;

  logic [7:0]             split_char_r;
  logic [JW-1:0]          join_bytes_r;
  logic [2:0]             join_len_r;
  logic [MASK_FIELDS-1:0] pick_mask_r;
  logic [15:0]            pick_from_r;
  logic                   drop_r;

  logic [15:0]   field_num_r, field_num_nxt;
  logic          none_out_r, none_out_nxt;
  logic          delim_seen_r, delim_seen_nxt;
  logic          has_content_r, has_content_nxt;
  logic [CW-1:0] hold_cnt_r, hold_cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          flush_pend_r, flush_pend_nxt;

  logic          accept;
  logic [15:0]   fn_inc;
  logic          sel_cur, sel_inc;
  logic          is_nl, content;
  logic [2:0]    join_n;
  logic [CW-1:0] flush_n;
  logic [2:0]    tail_len;
  logic [31:0]   tail_data;
  logic          rec_ovf;

  function automatic logic sel_field(input logic [15:0] f,
                                     input logic [MASK_FIELDS-1:0] mask,
                                     input logic [15:0] from);
    logic [15:0] fm1;
    logic        in_rng;
    fm1    = f - 16'd1;
    in_rng = (f != 16'd0) && (f <= 16'(MASK_FIELDS));
    return (in_rng && mask[fm1[MIW-1:0]]) || ((from != 16'd0) && (f >= from));
  endfunction

  assign accept  = in_valid && in_ready;
  assign fn_inc  = (field_num_r == 16'hFFFF) ? field_num_r : field_num_r + 16'd1;
  assign sel_cur = sel_field(field_num_r, pick_mask_r, pick_from_r);
  assign sel_inc = sel_field(fn_inc, pick_mask_r, pick_from_r);
  assign is_nl   = in_has && in_last && (in_byte == NL_BYTE);
  assign content = in_has && !is_nl;
  assign join_n  = (join_len_r > 3'(JOIN_LIM)) ? 3'(JOIN_LIM) : join_len_r;

  assign hold_waddr = hold_cnt_r[AW-1:0];
  assign hold_wdata = in_byte;
  assign in_ready   = !q_full && !flush_pend_r;
  assign flush_pend = flush_pend_r;

  always_comb begin
    field_num_nxt   = field_num_r;
    none_out_nxt    = none_out_r;
    delim_seen_nxt  = delim_seen_r;
    has_content_nxt = has_content_r;
    hold_cnt_nxt    = hold_cnt_r;
    ovf_nxt         = ovf_r;
    flush_n         = '0;
    tail_len        = 3'd0;
    tail_data       = 32'd0;
    hold_we         = 1'b0;
    rec_ovf         = ovf_r;
    if (accept) begin
      if (content) begin
        if (!has_content_r) begin
          has_content_nxt = 1'b1;
          if (sel_cur) begin
            none_out_nxt = 1'b0;
          end
        end
        if (in_byte == split_char_r) begin
          flush_n        = hold_cnt_r;
          hold_cnt_nxt   = '0;
          delim_seen_nxt = 1'b1;
          field_num_nxt  = fn_inc;
          if (sel_inc) begin
            if (!none_out_nxt) begin
              tail_len  = join_n;
              tail_data = 32'(join_bytes_r);
            end
            none_out_nxt = 1'b0;
          end
        end else if (sel_cur) begin
          if (drop_r && !delim_seen_r) begin
            // Field one is held until a delimiter shows the line is kept.
            if (hold_cnt_r < CW'(HOLD_DEPTH)) begin
              hold_we      = 1'b1;
              hold_cnt_nxt = hold_cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            flush_n      = hold_cnt_r;
            hold_cnt_nxt = '0;
            tail_len     = 3'd1;
            tail_data    = {24'd0, in_byte};
          end
        end
      end
      rec_ovf = ovf_nxt;
      if (in_last) begin
        // A line with content but no delimiter vanishes in drop mode.
        if (!(has_content_nxt && drop_r && !delim_seen_nxt)) begin
          if (hold_cnt_nxt != '0) begin
            flush_n = hold_cnt_nxt;
          end
          if (is_nl) begin
            tail_len  = 3'd1;
            tail_data = {24'd0, NL_BYTE};
          end
        end
        field_num_nxt   = 16'd1;
        none_out_nxt    = 1'b1;
        delim_seen_nxt  = 1'b0;
        has_content_nxt = 1'b0;
        hold_cnt_nxt    = '0;
        ovf_nxt         = 1'b0;
      end
    end
  end

  assign q_push = accept && ((flush_n != '0) || (tail_len != 3'd0));

  always_comb begin
    q_cmd.flush_n   = HOLD_CNT_W'(flush_n);
    q_cmd.tail_len  = tail_len;
    q_cmd.tail_data = tail_data;
    q_cmd.ovf       = rec_ovf;
    q_cmd.line_end  = in_last;
  end

  // The input waits while a flush is pending so that new held bytes never
  // overwrite entries the back has not read yet.
  always_comb begin
    flush_pend_nxt = flush_pend_r;
    if (flush_done) begin
      flush_pend_nxt = 1'b0;
    end else if (q_push && (flush_n != '0)) begin
      flush_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_char_r  <= TAB_BYTE;
      join_bytes_r  <= JW'(TAB_BYTE);
      join_len_r    <= 3'd1;
      pick_mask_r   <= '0;
      pick_from_r   <= 16'd0;
      drop_r        <= 1'b0;
      field_num_r   <= 16'd1;
      none_out_r    <= 1'b1;
      delim_seen_r  <= 1'b0;
      has_content_r <= 1'b0;
      hold_cnt_r    <= '0;
      ovf_r         <= 1'b0;
      flush_pend_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SPLIT_CHAR: split_char_r <= cfg_wdata[7:0];
          CFG_JOIN_BYTES: join_bytes_r <= cfg_wdata[JW-1:0];
          CFG_JOIN_LEN:   join_len_r   <= cfg_wdata[2:0];
          CFG_PICK_MASK:  pick_mask_r  <= cfg_wdata[MASK_FIELDS-1:0];
          CFG_PICK_FROM:  pick_from_r  <= cfg_wdata[15:0];
          CFG_DROP_PLAIN: drop_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
      field_num_r   <= field_num_nxt;
      none_out_r    <= none_out_nxt;
      delim_seen_r  <= delim_seen_nxt;
      has_content_r <= has_content_nxt;
      hold_cnt_r    <= hold_cnt_nxt;
      ovf_r         <= ovf_nxt;
      flush_pend_r  <= flush_pend_nxt;
    end
  end

endmodule

// ----- sv/dfc_back.sv -----
// ----------------------------------------------------------------------------
// dfc_back: output sequencer of the delimited field cutter
// Expands each request into output bytes, one per cycle while the output
// queue has room: held bytes read from the hold store first, then the tail bytes.
// ----------------------------------------------------------------------------
module dfc_back
  import dfc_pkg::*;
#(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  cmd_t                          q_cmd,
  output logic                          hold_re,
  output logic [$clog2(HOLD_DEPTH)-1:0] hold_raddr,
  input  logic [7:0]                    hold_rdata,
  output logic                          flush_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_run_last,
  output logic                          out_line_done,
  output logic                          out_ovf
);

  localparam int AW       = $clog2(HOLD_DEPTH);
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [7:0] b;
    logic       run_last;
    logic       line_done;
    logic       ovf;
  } res_t;

  cmd_t                  cur_r;
  logic                  cur_valid_r;
  logic [HOLD_CNT_W-1:0] fidx_r;
  logic [1:0]            tidx_r;

  logic       s1_valid_r;
  logic       s1_from_ram_r;
  logic [7:0] s1_byte_r;
  logic       s1_run_last_r;
  logic       s1_line_done_r;
  logic       s1_ovf_r;

  res_t       oq_r [OQ_DEPTH];
  logic [1:0] oq_wr_r, oq_rd_r;
  logic [2:0] oq_cnt_r;

  logic can_issue, issue, in_flush, flush_end, tail_end, rec_end, oq_pop;
  res_t oq_in;

  // Room is reserved for the byte still in the read stage.
  assign can_issue = (4'(oq_cnt_r) + 4'(s1_valid_r)) < 4'(OQ_DEPTH);
  assign issue     = cur_valid_r && can_issue;
  assign in_flush  = fidx_r < cur_r.flush_n;
  assign flush_end = (fidx_r + HOLD_CNT_W'(1)) == cur_r.flush_n;
  assign tail_end  = ({1'b0, tidx_r} + 3'd1) == cur_r.tail_len;
  assign rec_end   = in_flush ? (flush_end && (cur_r.tail_len == 3'd0)) : tail_end;

  assign q_pop      = !q_empty && (!cur_valid_r || (issue && rec_end));
  assign hold_re    = issue && in_flush;
  assign hold_raddr = fidx_r[AW-1:0];
  assign flush_done = issue && in_flush && flush_end;

  assign oq_pop = (oq_cnt_r != 3'd0) && out_ready;

  always_comb begin
    oq_in.b         = s1_from_ram_r ? hold_rdata : s1_byte_r;
    oq_in.run_last  = s1_run_last_r;
    oq_in.line_done = s1_line_done_r;
    oq_in.ovf       = s1_ovf_r;
  end

  assign out_valid     = oq_cnt_r != 3'd0;
  assign out_byte      = oq_r[oq_rd_r].b;
  assign out_run_last  = oq_r[oq_rd_r].run_last;
  assign out_line_done = oq_r[oq_rd_r].line_done;
  assign out_ovf       = oq_r[oq_rd_r].ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      oq_wr_r     <= 2'd0;
      oq_rd_r     <= 2'd0;
      oq_cnt_r    <= 3'd0;
    end else begin
      if (q_pop) begin
        cur_r       <= q_cmd;
        cur_valid_r <= 1'b1;
        fidx_r      <= '0;
        tidx_r      <= 2'd0;
      end else if (issue && rec_end) begin
        cur_valid_r <= 1'b0;
      end else if (issue) begin
        if (in_flush) begin
          fidx_r <= fidx_r + HOLD_CNT_W'(1);
        end else begin
          tidx_r <= tidx_r + 2'd1;
        end
      end

      s1_valid_r <= issue;
      if (issue) begin
        s1_from_ram_r  <= in_flush;
        s1_byte_r      <= cur_r.tail_data[{tidx_r, 3'b000} +: 8];
        s1_run_last_r  <= rec_end;
        s1_line_done_r <= rec_end && cur_r.line_end;
        s1_ovf_r       <= cur_r.ovf;
      end

      if (s1_valid_r) begin
        oq_r[oq_wr_r] <= oq_in;
        oq_wr_r       <= oq_wr_r + 2'd1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 2'd1;
      end
      oq_cnt_r <= oq_cnt_r + 3'(s1_valid_r) - 3'(oq_pop);
    end
  end

endmodule

// ----- sv/delimited_field_cutter_top.sv -----
// ----------------------------------------------------------------------------
// delimited_field_cutter_top: byte-stream field cutter
// Usage: one byte of a text line enters per request on the in_ channel; the
// line ends at the request with in_tlast. Bytes of the selected fields leave
// on the out_ channel, one per request, with the output delimiter between
// selected fields and the trailing newline kept. out_tlast marks the byte
// that completes a line, out_tuser[0] the last byte caused by one input
// request, out_tuser[1] a line whose held first field overflowed.
// A request passes through the request queue, the current-request register,
// the read stage and the output queue before its first result appears.
// Pass-through bytes flow at one per cycle unless stalled. Held bytes are
// read one by one from the hold store; no input is taken after their release
// is queued until the last one has been read. When the receiver stalls, a
// four-entry output queue and a two-entry request queue fill, then in_tready
// drops. Reset (synchronous, rst_n low) restores the default configuration,
// starts a fresh line and empties all queues. The user must write the
// configuration port only while no line is in progress and all results are
// delivered; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module delimited_field_cutter_top
  import dfc_pkg::*;
#(
  parameter int HOLD_DEPTH  = 32,
  parameter int MASK_FIELDS = 64,
  parameter int JOIN_MAX    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // line_last
  // Result requests.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [0] run_last, [1] hold_overflow
  output logic        out_tlast,  // line_done
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int AW = $clog2(HOLD_DEPTH);

  logic          q_push, q_full, q_pop, q_empty;
  cmd_t          q_din, q_dout;
  logic          hold_we, hold_re;
  logic [AW-1:0] hold_waddr, hold_raddr;
  logic [7:0]    hold_wdata, hold_rdata;
  logic          flush_done, flush_pend;

  // The front classifies each byte against the field selection and decides
  // what the line emits; it writes held first-field bytes into the store.
  dfc_front #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .MASK_FIELDS(MASK_FIELDS),
    .JOIN_MAX   (JOIN_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_has    (in_tuser),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_din),
    .hold_we   (hold_we),
    .hold_waddr(hold_waddr),
    .hold_wdata(hold_wdata),
    .flush_done(flush_done),
    .flush_pend(flush_pend)
  );

  dfc_cmd_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  // Hold store for the first field of a line in drop mode.
  dfc_ram #(
    .WIDTH(8),
    .DEPTH(HOLD_DEPTH)
  ) u_hold (
    .clk  (clk),
    .we   (hold_we),
    .waddr(hold_waddr),
    .wdata(hold_wdata),
    .re   (hold_re),
    .raddr(hold_raddr),
    .rdata(hold_rdata)
  );

  // The back turns each request into output bytes at one byte per cycle unless stalled.
  dfc_back #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_cmd        (q_dout),
    .hold_re      (hold_re),
    .hold_raddr   (hold_raddr),
    .hold_rdata   (hold_rdata),
    .flush_done   (flush_done),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_run_last (out_tuser[0]),
    .out_line_done(out_tlast),
    .out_ovf      (out_tuser[1])
  );

  // A release of held bytes can only finish if the front queued one.
  a_flush_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    flush_done |-> flush_pend)
    else $error("held-byte release finished with none pending");

  // The hold store is never written while its bytes are being released.
  a_no_hold_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    hold_we |-> !flush_pend)
    else $error("hold store written during a release");

  // The request queue is never pushed when full.
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overrun");

endmodule

// ----- bench/delimited_field_cutter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_cutter_checker: result predictor and scoreboard
// Watches the input, result and configuration ports of the field cutter,
// predicts the bytes each accepted input request must produce and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module delimited_field_cutter_checker
  import dfc_pkg::*;
#(
  parameter int HOLD_DEPTH  = 32,
  parameter int MASK_FIELDS = 64,
  parameter int JOIN_MAX    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // line_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic [1:0]  out_tuser,  // [0] run_last, [1] hold_overflow
  input  logic        out_tlast,  // line_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          bytes_owed
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       line_done;
    logic       hold_overflow;
  } cut_byte_t;

  // Register copy.
  logic [7:0]  split_char;
  logic [31:0] join_bytes;
  logic [2:0]  join_len;
  logic [63:0] pick_mask;
  logic [15:0] pick_from;
  logic        drop_plain;

  // Line state.
  logic [15:0] field_idx;
  logic        none_sent;
  logic        delim_hit;
  logic        line_started;
  logic [7:0]  hold_buf [HOLD_DEPTH];
  int          hold_cnt;
  logic        hold_lost;

  cut_byte_t owed_q[$];
  cut_byte_t step_q[$];

  function automatic logic field_picked(input logic [15:0] f);
    logic [15:0] fm1;
    fm1 = f - 16'd1;
    if (f >= 16'd1 && f <= MASK_FIELDS && pick_mask[fm1[5:0]]) return 1'b1;
    return (pick_from != 16'd0) && (f >= pick_from);
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    cut_byte_t r;
    r.out_byte      = b;
    r.run_last      = 1'b0;
    r.line_done     = 1'b0;
    r.hold_overflow = hold_lost;
    step_q.push_back(r);
  endfunction

  function automatic void release_held();
    for (int k = 0; k < hold_cnt; k++) emit_byte(hold_buf[k]);
    hold_cnt = 0;
  endfunction

  function automatic void emit_join();
    int n;
    n = join_len;
    if (n > JOIN_MAX) n = JOIN_MAX;
    if (n > JOIN_BYTES_MAX) n = JOIN_BYTES_MAX;
    for (int k = 0; k < n; k++) emit_byte(join_bytes[8*k +: 8]);
  endfunction

  function automatic void start_line();
    field_idx    = 16'd1;
    none_sent    = 1'b1;
    delim_hit    = 1'b0;
    line_started = 1'b0;
    hold_cnt     = 0;
    hold_lost    = 1'b0;
  endfunction

  function automatic void take_content(input logic [7:0] b);
    if (!line_started) begin
      line_started = 1'b1;
      if (field_picked(field_idx)) none_sent = 1'b0;
    end
    if (b == split_char) begin
      release_held();
      delim_hit = 1'b1;
      if (field_idx != 16'hFFFF) field_idx = field_idx + 16'd1;
      if (field_picked(field_idx)) begin
        if (!none_sent) emit_join();
        none_sent = 1'b0;
      end
    end else if (field_picked(field_idx)) begin
      // In drop mode the first field waits until a delimiter proves the line.
      if (drop_plain && !delim_hit) begin
        if (hold_cnt < HOLD_DEPTH) begin
          hold_buf[hold_cnt] = b;
          hold_cnt++;
        end else begin
          hold_lost = 1'b1;
        end
      end else begin
        release_held();
        emit_byte(b);
      end
    end
  endfunction

  function automatic void cut_request(input logic [7:0] b, input logic has,
                                      input logic last);
    logic      nl_end;
    logic      dropped;
    cut_byte_t r;
    nl_end = 1'b0;
    step_q.delete();
    if (has) begin
      if (last && b == NL_BYTE) nl_end = 1'b1;
      else take_content(b);
    end
    if (last) begin
      dropped = line_started && drop_plain && !delim_hit;
      if (!dropped) begin
        release_held();
        if (nl_end) emit_byte(NL_BYTE);
      end
      start_line();
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      if (last) r.line_done = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) owed_q.push_back(step_q[i]);
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      CFG_SPLIT_CHAR: split_char = val[7:0];
      CFG_JOIN_BYTES: join_bytes = val[31:0];
      CFG_JOIN_LEN:   join_len   = val[2:0];
      CFG_PICK_MASK:  pick_mask  = val;
      CFG_PICK_FROM:  pick_from  = val[15:0];
      CFG_DROP_PLAIN: drop_plain = val[0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    cut_byte_t want;
    if (!rst_n) begin
      split_char = TAB_BYTE;
      join_bytes = 32'(TAB_BYTE);
      join_len   = 3'd1;
      pick_mask  = '0;
      pick_from  = '0;
      drop_plain = 1'b0;
      start_line();
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) apply_write(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) cut_request(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: out_byte %02h with nothing expected", out_tdata);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_tdata);
            fail_count++;
          end
          if (out_tuser[0] !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_tuser[0]);
            fail_count++;
          end
          if (out_tlast !== want.line_done) begin
            $error("line_done: expected %0b, got %0b", want.line_done, out_tlast);
            fail_count++;
          end
          if (out_tuser[1] !== want.hold_overflow) begin
            $error("hold_overflow: expected %0b, got %0b", want.hold_overflow,
                   out_tuser[1]);
            fail_count++;
          end
        end
      end
    end
    bytes_owed = owed_q.size();
  end

endmodule

// ----- bench/delimited_field_cutter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_cutter_top_tb: stimulus and verdict for the field cutter
// Feeds text lines into the cutter a byte per request under many delimiter,
// selection and drop settings, with random gaps on both channels and one
// long receiver stall. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module delimited_field_cutter_top_tb;
  import dfc_pkg::*;

  // The slowest legal run (every request producing its most results, each
  // behind the longest receiver stall, plus every settle pause) stays well
  // under this.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet time after the last owed byte: covers the pipeline latency plus a
  // full release of held bytes from requests that produce nothing visible.
  localparam int SETTLE_CYCLES = 48;
  localparam int SQUEEZE_CYCLES = 250;
  localparam int RANDOM_ITEMS = 330;
  localparam int PHASE_ITEMS = 30;
  localparam logic [2:0] CFG_SPARE_IDX = 3'd6;
  localparam logic [7:0] COMMA = 8'h2C;
  localparam int PHASE_EXTREME_LOW  = 0;
  localparam int PHASE_EXTREME_HIGH = 1;

  typedef enum int {END_NL, END_BARE, END_ON_BYTE} line_end_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [63:0] cfg_wdata;

  int fail_count;
  int bytes_owed;
  int cycle_cnt = 0;
  int items_sent;

  // Stimulus needs to know the live delimiter and drop mode to shape lines.
  logic [7:0] split_now;
  logic       drop_now;

  // Pacing controls: steady modes give stretches with no idle cycles.
  bit tx_steady;
  bit rx_steady;
  bit squeeze_armed;
  bit squeeze_done;

  delimited_field_cutter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  delimited_field_cutter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver. Each result request waits out a random stall first, unless the
  // receiver is in a steady stretch. Once, on request from the stimulus, it
  // holds off for a long count of cycles so that the output queue and the
  // request queue fill and the cutter has to drop in_tready.
  initial begin : receiver
    int stall;
    bit squeeze_taken;
    squeeze_taken = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 11);
      if (squeeze_armed && !squeeze_taken) begin
        stall = SQUEEZE_CYCLES;
        squeeze_taken = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // One configuration write. The enable is raised and lowered on separate
  // falling edges, so back-to-back writes never collide in one time step.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one input request and wait for the cutter to take it. A zero gap
  // keeps tvalid high straight from the previous request.
  task automatic offer_item(input logic [7:0] b, input logic has, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // A bare request that does not end a line is ignored by the cutter.
    if (has || last) items_sent++;
  endtask

  // Stop offering, wait until every predicted byte has arrived, then leave
  // the cutter time to finish requests that produce no result at all.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Send the characters of a string as one line, ended as asked.
  task automatic send_line(input string s, input line_end_t ending);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++)
      offer_item(s[i], 1'b1, (ending == END_ON_BYTE) && (i == n - 1));
    if (ending == END_NL) offer_item(NL_BYTE, 1'b1, 1'b1);
    else if (ending == END_BARE) offer_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // A random line built from fields. Most lines are well formed so that
  // selection, joining and holding all get exercised; a few requests are
  // plain noise with random flags.
  task automatic send_random_line();
    int         n_fields;
    int         f_len;
    int         pick;
    logic [7:0] b;
    logic [7:0] line_q[$];
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6))
        offer_item(8'($urandom), 1'($urandom), 1'($urandom));
      return;
    end
    n_fields = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 70) : $urandom_range(1, 6);
    for (int f = 1; f <= n_fields; f++) begin
      if (f > 1) line_q.push_back(split_now);
      // Long first fields in drop mode can run past the hold store.
      if (f == 1 && drop_now && $urandom_range(0, 3) == 0) f_len = $urandom_range(28, 40);
      else f_len = $urandom_range(0, 4);
      repeat (f_len) begin
        b = 8'($urandom);
        if (b == split_now) b = b ^ 8'h01;
        line_q.push_back(b);
      end
    end
    pick = $urandom_range(0, 9);
    foreach (line_q[i]) begin
      // Bare requests inside a line must change nothing.
      if ($urandom_range(0, 19) == 0) offer_item(8'($urandom), 1'b0, 1'b0);
      offer_item(line_q[i], 1'b1, (pick >= 8) && (i == line_q.size() - 1));
    end
    if (pick < 6) offer_item(NL_BYTE, 1'b1, 1'b1);
    else if (pick < 8 || line_q.size() == 0) offer_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Register settings for one random phase; the first two are the extremes.
  task automatic pick_settings(input int phase);
    logic [7:0]  sc;
    logic [31:0] jb;
    logic [2:0]  jl;
    logic [63:0] pm;
    logic [15:0] pf;
    logic        dp;
    case (phase)
      PHASE_EXTREME_LOW: begin
        sc = 8'h00; jb = '0; jl = 3'd0; pm = '1; pf = 16'd1; dp = 1'b1;
      end
      PHASE_EXTREME_HIGH: begin
        sc = 8'hFF; jb = '1; jl = 3'd7; pm = '0; pf = 16'd0; dp = 1'b0;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: sc = TAB_BYTE;
          1: sc = COMMA;
          2: sc = NL_BYTE;
          default: sc = 8'($urandom);
        endcase
        jb = $urandom;
        jl = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 2))
          0: pm = {$urandom, $urandom};
          1: pm = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 7));
          default: pm = 64'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0: pf = 16'd0;
          1: pf = 16'($urandom_range(1, 8));
          2: pf = 16'($urandom_range(9, 70));
          default: pf = 16'hFFFF;
        endcase
        dp = ($urandom_range(0, 2) == 0);
      end
    endcase
    cfg_write(CFG_SPLIT_CHAR, 64'(sc));
    cfg_write(CFG_JOIN_BYTES, 64'(jb));
    cfg_write(CFG_JOIN_LEN, 64'(jl));
    cfg_write(CFG_PICK_MASK, pm);
    cfg_write(CFG_PICK_FROM, 64'(pf));
    cfg_write(CFG_DROP_PLAIN, 64'(dp));
    // An index past the register list must leave every register alone.
    if (phase == PHASE_EXTREME_HIGH) cfg_write(CFG_SPARE_IDX, {$urandom, $urandom});
    split_now = sc;
    drop_now  = dp;
  endtask

  initial begin : stimulus
    int phase;
    int random_base;
    int phase_base;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    items_sent = 0;
    split_now = TAB_BYTE;
    drop_now  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: tab splits, nothing selected, so only the kept
    // newline comes out; a bare line end with nothing to say stays silent.
    send_line("a\tb", END_NL);
    offer_item(8'h5A, 1'b0, 1'b1);
    settle();

    // Comma splits, fields 1, 3 and 64 selected, a four-byte join asked for
    // with an oversized length that must saturate.
    cfg_write(CFG_SPLIT_CHAR, 64'(COMMA));
    cfg_write(CFG_JOIN_BYTES, 64'h0000_0000_FF00_2D3B);
    cfg_write(CFG_JOIN_LEN, 64'd7);
    cfg_write(CFG_PICK_MASK, 64'h8000_0000_0000_0005);
    cfg_write(CFG_PICK_FROM, 64'd0);
    cfg_write(CFG_DROP_PLAIN, 64'd0);
    split_now = COMMA;
    // Empty selected first field, so the join still appears before field 3.
    send_line(",x,y", END_NL);
    // Byte extremes and a newline in mid line are content; a bare request
    // in mid line is ignored; the line ends on its last content byte.
    offer_item(8'h00, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b1, 1'b0);
    offer_item(NL_BYTE, 1'b1, 1'b0);
    offer_item(8'hA5, 1'b0, 1'b0);
    offer_item("q", 1'b1, 1'b1);
    settle();

    // Drop mode with an empty join: a line without a delimiter vanishes, a
    // line with one releases its held first field at that delimiter.
    cfg_write(CFG_DROP_PLAIN, 64'd1);
    cfg_write(CFG_JOIN_LEN, 64'd0);
    drop_now = 1'b1;
    send_line("ab", END_NL);
    send_line("ab,c,d", END_NL);
    settle();

    // Random phases, each under fresh register settings.
    random_base = items_sent;
    phase = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      pick_settings(phase);
      phase++;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        if (!squeeze_done && items_sent - random_base >= 60) begin
          squeeze_armed = 1'b1;
          squeeze_done  = 1'b1;
        end
        tx_steady = ($urandom_range(0, 3) == 0);
        send_random_line();
      end
      // Noise may leave a line open; close it before touching registers.
      offer_item(8'($urandom), 1'b0, 1'b1);
      settle();
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
